// ===== src/dle_pkg.sv =====
// shared types and constants for the escape-delimited packet deframer
// no dependencies; every other file of the block depends on this package
package dle_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned LENGTH_W = 9;
  localparam int unsigned CFG_IDX_W = 8;

  // default sizing
  localparam int unsigned MAX_PAYLOAD_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ESCAPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_END = 8'd1;

  // configuration reset values
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h10;
  localparam logic [BYTE_W-1:0] END_RST = 8'h03;

  // framing state, codes match the reported parse_state
  typedef enum logic [STATE_W-1:0] {
    ST_EMPTY = 3'd0,
    ST_ESC1  = 3'd1,
    ST_DATA  = 3'd2,
    ST_ESC2  = 3'd3,
    ST_FULL  = 3'd4
  } state_e;

  // classified byte handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_esc;
    logic              is_end;
    logic              is_zero;
  } cls_t;

endpackage

// ===== src/dle_if.sv =====
// channel interfaces of the deframer: received bytes, results, config writes
// depends on dle_pkg for field widths
interface dle_byte_if;
  logic                       valid;
  logic                       ready;
  logic [dle_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface dle_result_if;
  logic                         valid;
  logic                         ready;
  logic [dle_pkg::STATE_W-1:0]  parse_state;
  logic                         byte_stored;
  logic [dle_pkg::BYTE_W-1:0]   payload_byte;
  logic [dle_pkg::INDEX_W-1:0]  payload_index;
  logic [dle_pkg::BYTE_W-1:0]   packet_id;
  logic [dle_pkg::LENGTH_W-1:0] payload_length;
  logic                         frame_done;
  logic                         frame_dropped;

  modport source (output valid, output parse_state, output byte_stored,
                  output payload_byte, output payload_index, output packet_id,
                  output payload_length, output frame_done, output frame_dropped,
                  input ready);
  modport sink (input valid, input parse_state, input byte_stored,
                input payload_byte, input payload_index, input packet_id,
                input payload_length, input frame_done, input frame_dropped,
                output ready);
endinterface

interface dle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dle_pkg::CFG_IDX_W-1:0] index;
  logic [dle_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/dle_front.sv =====
// front end: holds the escape and end registers, accepts bytes and classifies them
// depends on dle_pkg and the channel interfaces in dle_if.sv
module dle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  dle_cfg_if.sink         cfg_i,
  dle_byte_if.sink        rx_i,
  output logic            push_o,
  output dle_pkg::cls_t   push_data_o,
  input  logic            push_ready_i
);
  import dle_pkg::*;

  logic [BYTE_W-1:0] escape_q;
  logic [BYTE_W-1:0] end_q;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= ESCAPE_RST;
      end_q    <= END_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_IDX_ESCAPE) begin
        escape_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_IDX_END) begin
        end_q <= cfg_i.data;
      end
    end
  end

  // classify against the current delimiters and hand into the queue
  assign rx_i.ready = push_ready_i;
  assign push_o     = rx_i.valid && push_ready_i;

  always_comb begin
    push_data_o.data    = rx_i.in_byte;
    push_data_o.is_esc  = (rx_i.in_byte == escape_q);
    push_data_o.is_end  = (rx_i.in_byte == end_q);
    push_data_o.is_zero = (rx_i.in_byte == '0);
  end

endmodule

// ===== src/dle_fifo.sv =====
// short queue of classified bytes between the front and back ends
// depends on dle_pkg for the entry type
module dle_fifo #(
  parameter int unsigned DEPTH = dle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dle_pkg::cls_t push_data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output dle_pkg::cls_t pop_data_o,
  output logic          pop_valid_o
);
  import dle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/dle_back.sv =====
// back end: framing state machine, payload store and registered result
// depends on dle_pkg and the result interface in dle_if.sv
module dle_back #(
  parameter int unsigned MAX_PAYLOAD = dle_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  dle_pkg::cls_t pop_data_i,
  output logic          pop_o,
  dle_result_if.source  res_o
);
  import dle_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PAYLOAD);

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  held_q, held_d;
  logic [BYTE_W-1:0] id_q, id_d;
  logic              wr_en, done, dropped, full;
  logic              out_valid_q;
  logic [31:0]       held_ext, idx_ext;
  logic [BYTE_W-1:0] store_q [MAX_PAYLOAD];

  // take the next byte whenever the result register is free or drains
  assign pop_o = pop_valid_i && (!out_valid_q || res_o.ready);
  assign full  = (held_q == FULL_LEN);

  // next framing state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ESC1: begin
        if (pop_data_i.is_zero || pop_data_i.is_end) begin
          state_d = ST_EMPTY;
        end else if (pop_data_i.is_esc) begin
          state_d = ST_ESC1;
        end else begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (pop_data_i.is_esc) begin
          state_d = ST_ESC2;
        end else begin
          state_d = full ? ST_EMPTY : ST_DATA;
        end
      end
      ST_ESC2: begin
        if (pop_data_i.is_esc) begin
          state_d = full ? ST_EMPTY : ST_DATA;
        end else if (pop_data_i.is_end) begin
          state_d = ST_FULL;
        end else begin
          state_d = ST_DATA;
        end
      end
      default: begin
        state_d = pop_data_i.is_esc ? ST_ESC1 : ST_EMPTY;
      end
    endcase
  end

  // length, id and store write per byte
  always_comb begin
    held_d  = held_q;
    id_d    = id_q;
    wr_en   = 1'b0;
    done    = 1'b0;
    dropped = 1'b0;
    unique case (state_q)
      ST_ESC1: begin
        held_d = '0;
        if (pop_data_i.is_zero || pop_data_i.is_end) begin
          dropped = 1'b1;
        end else if (!pop_data_i.is_esc) begin
          id_d = pop_data_i.data;
        end
      end
      ST_DATA: begin
        if (!pop_data_i.is_esc) begin
          if (full) begin
            held_d  = '0;
            dropped = 1'b1;
          end else begin
            wr_en  = 1'b1;
            held_d = held_q + LEN_W'(1);
          end
        end
      end
      ST_ESC2: begin
        if (pop_data_i.is_esc) begin
          if (full) begin
            held_d  = '0;
            dropped = 1'b1;
          end else begin
            wr_en  = 1'b1;
            held_d = held_q + LEN_W'(1);
          end
        end else if (pop_data_i.is_end) begin
          done = 1'b1;
        end else begin
          id_d   = pop_data_i.data;
          held_d = '0;
        end
      end
      default: begin
        held_d = '0;
      end
    endcase
  end

  assign held_ext = 32'(held_d);
  assign idx_ext  = 32'(held_q);

  // framing state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
      held_q  <= '0;
      id_q    <= '0;
    end else if (pop_o) begin
      state_q <= state_d;
      held_q  <= held_d;
      id_q    <= id_d;
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (pop_o && wr_en) begin
      store_q[held_q[IDX_W-1:0]] <= pop_data_i.data;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_o.parse_state    <= state_d;
      res_o.byte_stored    <= wr_en;
      res_o.payload_byte   <= wr_en ? pop_data_i.data : '0;
      res_o.payload_index  <= wr_en ? idx_ext[INDEX_W-1:0] : '0;
      res_o.packet_id      <= id_d;
      res_o.payload_length <= held_ext[LENGTH_W-1:0];
      res_o.frame_done     <= done;
      res_o.frame_dropped  <= dropped;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

// ===== src/dle_etx_packet_deframer_core.sv =====
// top level of the escape-delimited packet deframer
// an accepted byte is written into the queue, then popped into the registered result
// throughput: one byte per cycle while res_o.ready is high; the framing state machine
//   in the back end updates once per byte and the queue decouples input and output stalls
// reset: asynchronous active low; empty state, length and id zero, delimiters
//   16 and 3, payload store not cleared (undefined until written)
module dle_etx_packet_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = dle_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = dle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dle_cfg_if.sink      cfg_i,
  dle_byte_if.sink     rx_i,
  dle_result_if.source res_o
);
  import dle_pkg::*;

  logic push, push_ready, pop, pop_valid;
  cls_t push_data, pop_data;

  // front end: delimiter registers and classification
  dle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .rx_i         (rx_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  dle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid)
  );

  // back end: framing and payload store
  dle_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
